>>> src/chk_pkg.sv
// Shared types, constants and the hash fold function of the chunk container checker.
package chk_pkg;

	localparam int LEN_BITS = 24;
	localparam logic [31:0] HASH_MUL = 32'hC2B0C3CC;
	localparam int END_CHUNK_BYTES = 12;

	// Configuration register indexes.
	localparam logic REG_TOTAL_LENGTH = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	typedef enum logic [2:0] {
		PH_TYPE     = 3'd0,
		PH_LEN      = 3'd1,
		PH_PAYLOAD  = 3'd2,
		PH_HASH     = 3'd3,
		PH_END_TYPE = 3'd4,
		PH_END_LEN  = 3'd5,
		PH_END_HASH = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_VERIFIED = 2'd1,
		KIND_COMPLETE = 2'd2,
		KIND_ERROR    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TOO_SHORT = 3'd1,
		ERR_OVERRUN   = 3'd2,
		ERR_HASH      = 3'd3,
		ERR_EARLY_END = 3'd4,
		ERR_TRUNCATED = 3'd5,
		ERR_END_LEN   = 3'd6
	} err_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] total_length;
		logic [31:0]         end_marker_type;
	} cfg_t;

	// Multiply by the hash constant and fold the 64-bit product into 32 bits.
	function automatic logic [31:0] fold_mul(input logic [31:0] h);
		logic [63:0] p;
		p = {32'd0, h} * {32'd0, HASH_MUL};
		return p[63:32] ^ p[31:0];
	endfunction

endpackage

>>> src/chk_queue.sv
// Two-entry byte queue between the input channel and the chunk engine.
module chk_queue (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] push_data,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output logic [7:0] pop_data
);
	import chk_pkg::*;

	logic [7:0] mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

>>> src/chk_engine.sv
// Chunk parser, hash unit and output register of the chunk container checker.
module chk_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  chk_pkg::cfg_t  cfg,
	input  logic           byte_valid,
	input  logic [7:0]     byte_data,
	output logic           byte_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     kind,
	output logic [7:0]     payload_byte,
	output logic [31:0]    chunk_type,
	output logic [2:0]     error_code
);
	import chk_pkg::*;

	localparam int PW = LEN_BITS + 1;
	localparam logic [PW-1:0] END_B = PW'(END_CHUNK_BYTES);

	phase_t              phase_q, phase_d;
	logic [1:0]          fbc_q, fbc_d;
	logic [LEN_BITS-1:0] pos_q, pos_d;
	logic [LEN_BITS-1:0] cs_q, cs_d;
	logic [31:0]         tw_q, tw_d;
	logic [31:0]         lw_q, lw_d;
	logic [31:0]         rem_q, rem_d;
	logic [31:0]         rh_q, rh_d;
	logic [1:0]          hbi_q, hbi_d;
	logic [31:0]         sh_q, sh_d;
	logic                disc_q, disc_d;
	logic [31:0]         final_q;

	logic                res_v;
	kind_t               res_kind;
	logic [7:0]          res_byte;
	err_t                res_err;
	logic [31:0]         res_type;

	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic [7:0]          pbyte_q;
	logic [31:0]         ctype_q;
	logic [2:0]          err_q;

	logic fire;

	assign byte_pop = byte_valid && (!out_valid_q || !out_stall);
	assign fire     = byte_pop;

	always_comb begin
		logic [LEN_BITS-1:0] tot;
		logic [LEN_BITS-1:0] npos;
		logic                failed;
		logic                rst_all;
		err_t                code;
		logic                done;
		logic [31:0]         hfin;
		logic [PW-1:0]       need;
		logic [7:0]          b;

		phase_d  = phase_q;
		fbc_d    = fbc_q;
		pos_d    = pos_q;
		cs_d     = cs_q;
		tw_d     = tw_q;
		lw_d     = lw_q;
		rem_d    = rem_q;
		rh_d     = rh_q;
		hbi_d    = hbi_q;
		sh_d     = sh_q;
		disc_d   = disc_q;
		res_v    = 1'b0;
		res_kind = KIND_PAYLOAD;
		res_byte = 8'd0;
		res_err  = ERR_NONE;
		failed   = 1'b0;
		rst_all  = 1'b0;
		code     = ERR_NONE;
		done     = 1'b0;
		need     = '0;
		b        = byte_data;
		tot      = cfg.total_length;
		npos     = pos_q + LEN_BITS'(1);
		hfin     = (hbi_q != 2'd0) ? final_q : rh_q;

		if (disc_q) begin
			pos_d = npos;
			if (npos >= tot) begin
				rst_all = 1'b1;
			end
		end else begin
			if (phase_q == PH_TYPE && fbc_q == 2'd0) begin
				cs_d  = pos_q;
				tw_d  = 32'd0;
				lw_d  = 32'd0;
				rh_d  = 32'd1;
				hbi_d = 2'd0;
				sh_d  = 32'd0;
				if ({1'b0, tot} < END_B) begin
					failed = 1'b1;
					code   = ERR_TOO_SHORT;
				end else if ({1'b0, pos_q} + END_B > {1'b0, tot}) begin
					failed = 1'b1;
					code   = ERR_TRUNCATED;
				end else if ({1'b0, pos_q} + END_B == {1'b0, tot}) begin
					phase_d = PH_END_TYPE;
				end
			end
			if (!failed) begin
				fbc_d = fbc_q + 2'd1;
				done  = (fbc_d == 2'd0);
				pos_d = npos;
				// Hash feed for every field but the stored hash.
				if (phase_d != PH_HASH && phase_d != PH_END_HASH) begin
					rh_d  = rh_d ^ ({24'd0, b} << {hbi_d, 3'b000});
					hbi_d = hbi_d + 2'd1;
					if (hbi_d == 2'd0) begin
						rh_d = fold_mul(rh_d);
					end
				end
				case (phase_d)
					PH_TYPE, PH_END_TYPE: begin
						tw_d = {tw_d[23:0], b};
						if (done) begin
							if (phase_d == PH_END_TYPE && tw_d != cfg.end_marker_type) begin
								failed = 1'b1;
								code   = ERR_TRUNCATED;
							end else begin
								phase_d = (phase_d == PH_TYPE) ? PH_LEN : PH_END_LEN;
							end
						end
					end
					PH_LEN: begin
						lw_d = {lw_d[23:0], b};
						if (done) begin
							need = {1'b0, cs_q} + END_B;
							if (need > {1'b0, tot} ||
							    33'(lw_d) > 33'({1'b0, tot} - need)) begin
								failed = 1'b1;
								code   = ERR_OVERRUN;
							end else begin
								rem_d   = lw_d;
								phase_d = (lw_d != 32'd0) ? PH_PAYLOAD : PH_HASH;
							end
						end
					end
					PH_PAYLOAD: begin
						fbc_d = 2'd0;
						rem_d = rem_q - 32'd1;
						if (rem_d == 32'd0) begin
							phase_d = PH_HASH;
						end
						res_v    = 1'b1;
						res_kind = KIND_PAYLOAD;
						res_byte = b;
					end
					PH_HASH: begin
						sh_d = {sh_q[23:0], b};
						if (done) begin
							if (sh_d != hfin) begin
								failed = 1'b1;
								code   = ERR_HASH;
							end else if (tw_q == cfg.end_marker_type) begin
								failed = 1'b1;
								code   = ERR_EARLY_END;
							end else if ({1'b0, npos} + END_B > {1'b0, tot}) begin
								failed = 1'b1;
								code   = ERR_TRUNCATED;
							end else begin
								phase_d  = PH_TYPE;
								res_v    = 1'b1;
								res_kind = KIND_VERIFIED;
							end
						end
					end
					PH_END_LEN: begin
						lw_d = {lw_d[23:0], b};
						if (done) begin
							if (lw_d != 32'd0) begin
								failed = 1'b1;
								code   = ERR_END_LEN;
							end else begin
								phase_d = PH_END_HASH;
							end
						end
					end
					PH_END_HASH: begin
						sh_d = {sh_q[23:0], b};
						if (done) begin
							if (sh_d != hfin) begin
								failed = 1'b1;
								code   = ERR_HASH;
							end else begin
								res_v    = 1'b1;
								res_kind = KIND_COMPLETE;
								rst_all  = 1'b1;
							end
						end
					end
					default: rst_all = 1'b1;
				endcase
			end
			if (failed) begin
				res_v    = 1'b1;
				res_kind = KIND_ERROR;
				res_err  = code;
				if (npos >= tot) begin
					rst_all = 1'b1;
				end else begin
					disc_d = 1'b1;
					pos_d  = npos;
				end
			end
		end
		res_type = tw_d;

		if (rst_all) begin
			phase_d = PH_TYPE;
			fbc_d   = 2'd0;
			pos_d   = '0;
			cs_d    = '0;
			tw_d    = 32'd0;
			lw_d    = 32'd0;
			rem_d   = 32'd0;
			rh_d    = 32'd1;
			hbi_d   = 2'd0;
			sh_d    = 32'd0;
			disc_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			fbc_q   <= 2'd0;
			pos_q   <= '0;
			cs_q    <= '0;
			tw_q    <= 32'd0;
			lw_q    <= 32'd0;
			rem_q   <= 32'd0;
			rh_q    <= 32'd1;
			hbi_q   <= 2'd0;
			sh_q    <= 32'd0;
			disc_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			pos_q   <= pos_d;
			cs_q    <= cs_d;
			tw_q    <= tw_d;
			lw_q    <= lw_d;
			rem_q   <= rem_d;
			rh_q    <= rh_d;
			hbi_q   <= hbi_d;
			sh_q    <= sh_d;
			disc_q  <= disc_d;
		end
	end

	// Final hash of a partial tail word, registered from the running hash.
	always_ff @(posedge clk) begin
		final_q <= fold_mul(rh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_v;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_v) begin
			kind_q  <= res_kind;
			pbyte_q <= res_byte;
			ctype_q <= res_type;
			err_q   <= res_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = pbyte_q;
	assign chunk_type   = ctype_q;
	assign error_code   = err_q;
endmodule

>>> src/chunk_container_checker_core.sv
// Top level of the chunk container checker: configuration registers, byte queue and engine.
//
// Channel   Direction  Handshake          Word
// input     in         in_valid/in_stall  data_byte
// output    out        out_valid/out_stall kind, payload_byte, chunk_type, error_code
// config    in         cfg_we             cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the engine retires one queued byte
// per cycle when not held by the output, using the hash multiplier once per four bytes
// inside that cycle; an accepted byte passes the queue before its result is registered.
// Reset (arst_n low) empties the queue and returns the parser to the type header.
// A stalled valid output holds the engine; the two-entry queue then fills, raising in_stall.
module chunk_container_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [31:0] chunk_type,
	output logic [2:0]  error_code,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import chk_pkg::*;

	cfg_t       cfg_q;
	logic       q_full;
	logic       q_valid;
	logic [7:0] q_data;
	logic       q_pop;

	// Configuration registers; the user writes only while the checker is idle (unenforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_TOTAL_LENGTH) begin
				cfg_q.total_length <= LEN_BITS'(cfg_data[23:0]);
			end else begin
				cfg_q.end_marker_type <= cfg_data;
			end
		end
	end

	assign in_stall = q_full;

	chk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (data_byte),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	chk_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.byte_valid   (q_valid),
		.byte_data    (q_data),
		.byte_pop     (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.chunk_type   (chunk_type),
		.error_code   (error_code)
	);
endmodule
